>>> rtl/pdwg_pkg.sv
// Shared types and constants for the PLL divider word generator.
// No dependencies; used by the controller, datapath and top level.
package pdwg_pkg;

  localparam logic [31:0] RX_OFFSET_HZ  = 32'd73350000;
  localparam logic [8:0]  DIV_MIN       = 9'd6;
  localparam logic [8:0]  DIV_MAX       = 9'd505;
  localparam logic [23:0] INT_PRE_WORD  = 24'h1ff843;
  localparam logic [23:0] INT_POST_WORD = 24'h1ff842;
  localparam logic [4:0]  BITS_FRAC     = 5'd16;
  localparam logic [4:0]  BITS_INT      = 5'd24;

  localparam logic [1:0] TGT_FRAC = 2'd0;
  localparam logic [1:0] TGT_LO2  = 2'd1;
  localparam logic [1:0] TGT_REF  = 2'd2;

  localparam logic [1:0] CFG_REF_HZ  = 2'd0;
  localparam logic [1:0] CFG_REF_DIV = 2'd1;
  localparam logic [1:0] CFG_LOCK    = 2'd2;
  localparam logic [1:0] CFG_PUMP    = 2'd3;

  // Divider operations: the datapath runs one restoring division at a time.
  typedef enum logic [2:0] {
    OP_FPD,   // fpd  = ref / (rdiv+1)
    OP_N,     // n    = (2f+fpd) / (2fpd)
    OP_FRAC,  // frac = (mag<<19 + fpd) / (2fpd)
    OP_GCD,   // rem  = a % b
    OP_RDIV,  // R    = ref / g
    OP_NDIV   // N    = freq / g
  } div_op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;      // capture the request
    logic    div_start; // begin a division
    div_op_t op;
    logic    div_step;  // one quotient bit
    logic    resid;     // compute residual after N
    logic    gcd_swap;  // a<=b, b<=rem
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic fpd_zero;
    logic int_zero;
    logic gcd_zero;
  } dp_stat_t;

endpackage

>>> rtl/pdwg_datapath.sv
// Datapath: request registers, a shared 64-bit restoring divider and the
// GCD/residual registers. Depends on pdwg_pkg.
module pdwg_datapath (
  input  logic                clk,
  input  logic [1:0]          in_target,
  input  logic [31:0]         in_freq_hz,
  input  logic [31:0]         reference_hz,
  input  logic [4:0]          reference_divider,
  input  pdwg_pkg::dp_cmd_t   cmd,
  output pdwg_pkg::dp_stat_t  stat,
  output logic [8:0]          div_word,
  output logic [17:0]         frac_word,
  output logic [31:0]         r_div,
  output logic [31:0]         n_div,
  output logic [1:0]          target_q
);

  logic [31:0] f_r, freq_r, fpd_r, a_r, b_r;
  logic [33:0] n_r;
  logic [63:0] num_r, quo_r;
  logic [64:0] rem_r;
  logic [63:0] den_r;
  logic [6:0]  cnt_r;
  logic        neg_r;
  logic [17:0] frac_r;
  logic [31:0] rd_r, nd_r;
  logic [1:0]  tgt_r;
  logic [63:0] num_nxt, den_nxt;
  logic [64:0] trial;
  logic [33:0] rdiff;
  logic        rneg;

  // Operand selection for each division kind.
  always_comb begin
    num_nxt = '0;
    den_nxt = '0;
    unique case (cmd.op)
      pdwg_pkg::OP_FPD: begin
        num_nxt = {32'd0, reference_hz};
        den_nxt = {58'd0, 6'({1'b0, reference_divider} + 6'd1)};
      end
      pdwg_pkg::OP_N: begin
        num_nxt = {31'd0, f_r, 1'b0} + {32'd0, fpd_r};
        den_nxt = {31'd0, fpd_r, 1'b0};
      end
      pdwg_pkg::OP_FRAC: begin
        num_nxt = (num_r << 19) + {32'd0, fpd_r};
        den_nxt = {31'd0, fpd_r, 1'b0};
      end
      pdwg_pkg::OP_GCD: begin
        num_nxt = {32'd0, a_r};
        den_nxt = {32'd0, b_r};
      end
      pdwg_pkg::OP_RDIV: begin
        num_nxt = {32'd0, reference_hz};
        den_nxt = {32'd0, a_r};
      end
      default: begin
        num_nxt = {32'd0, freq_r};
        den_nxt = {32'd0, a_r};
      end
    endcase
  end

  assign trial = {rem_r[63:0], quo_r[63]} - {1'b0, den_r};

  // The residual f - N*Fpd follows from the N division remainder: it is
  // (rem - Fpd)/2, and the difference is always even.
  assign rneg  = (rem_r[33:0] < {2'b00, fpd_r});
  assign rdiff = rneg ? ({2'b00, fpd_r} - rem_r[33:0]) : (rem_r[33:0] - {2'b00, fpd_r});

  // Division steps and result capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r  <= in_target;
      freq_r <= in_freq_hz;
      f_r    <= in_freq_hz + pdwg_pkg::RX_OFFSET_HZ;
      a_r    <= in_freq_hz;
      b_r    <= reference_hz;
    end
    if (cmd.div_start) begin
      quo_r <= num_nxt;
      rem_r <= '0;
      den_r <= den_nxt;
      cnt_r <= 7'd64;
    end else if (cmd.div_step && cnt_r != 7'd0) begin
      cnt_r <= cnt_r - 7'd1;
      if (!trial[64]) begin
        rem_r <= trial;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[63:0], quo_r[63]};
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    if (stat.div_done && cmd.div_step) begin
      unique case (cmd.op)
        pdwg_pkg::OP_FPD:  fpd_r <= quo_r[31:0];
        pdwg_pkg::OP_N:    n_r   <= quo_r[33:0];
        pdwg_pkg::OP_FRAC:
          frac_r <= neg_r ? 18'(19'h40000 - 19'(quo_r[18:0])) : quo_r[17:0];
        pdwg_pkg::OP_GCD:  num_r <= {32'd0, rem_r[31:0]};
        pdwg_pkg::OP_RDIV: rd_r  <= quo_r[31:0];
        default:           nd_r  <= quo_r[31:0];
      endcase
    end
    if (cmd.resid) begin
      neg_r <= rneg;
      num_r <= {31'd0, rdiff[33:1]};
    end
    if (cmd.gcd_swap) begin
      a_r <= b_r;
      b_r <= num_r[31:0];
    end
  end

  // Clamp of N-32 into the divider range; wraps to the top below 32.
  always_comb begin
    if (n_r < 34'd32) begin
      div_word = pdwg_pkg::DIV_MAX;
    end else if (n_r - 34'd32 < 34'(pdwg_pkg::DIV_MIN)) begin
      div_word = pdwg_pkg::DIV_MIN;
    end else if (n_r - 34'd32 > 34'(pdwg_pkg::DIV_MAX)) begin
      div_word = pdwg_pkg::DIV_MAX;
    end else begin
      div_word = 9'(n_r - 34'd32);
    end
  end

  assign frac_word     = frac_r;
  assign r_div         = rd_r;
  assign n_div         = nd_r;
  assign target_q      = tgt_r;
  assign stat.div_done = (cnt_r == 7'd0);
  assign stat.fpd_zero = (fpd_r == 32'd0);
  assign stat.int_zero = (freq_r == 32'd0) || (reference_hz == 32'd0);
  assign stat.gcd_zero = (b_r == 32'd0);

endmodule

>>> rtl/pdwg_ctrl.sv
// Controller: sequences divisions, Euclid loop and word emission.
// Depends on pdwg_pkg.
module pdwg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_target,
  input  pdwg_pkg::dp_stat_t stat,
  input  logic [1:0]         target_q,
  output pdwg_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               emit,
  output logic               emit_fault,
  output logic [3:0]         emit_idx
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV_GO, S_DIV_RUN, S_RESID, S_GCD_TEST, S_SWAP,
    S_EMIT, S_FAULT
  } state_t;

  state_t              state_r, state_nxt;
  pdwg_pkg::div_op_t   op_r, op_nxt;
  logic [3:0]          idx_r, idx_nxt;
  logic                idle;

  assign idle = (state_r == S_IDLE);

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && in_target != 2'd3) begin
          cmd.load  = 1'b1;
          op_nxt    = (in_target == pdwg_pkg::TGT_FRAC) ? pdwg_pkg::OP_FPD
                                                        : pdwg_pkg::OP_GCD;
          state_nxt = (in_target == pdwg_pkg::TGT_FRAC) ? S_DIV_GO : S_CHECK;
        end
      end
      S_CHECK: state_nxt = stat.int_zero ? S_FAULT : S_GCD_TEST;
      S_GCD_TEST: begin
        op_nxt    = stat.gcd_zero ? pdwg_pkg::OP_RDIV : pdwg_pkg::OP_GCD;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          unique case (op_r)
            pdwg_pkg::OP_FPD: begin
              op_nxt = pdwg_pkg::OP_N;
              state_nxt = S_CHECK;
            end
            pdwg_pkg::OP_N:    state_nxt = S_RESID;
            pdwg_pkg::OP_GCD:  state_nxt = S_SWAP;
            pdwg_pkg::OP_RDIV: begin
              op_nxt = pdwg_pkg::OP_NDIV;
              state_nxt = S_DIV_GO;
            end
            default: begin
              idx_nxt = 4'd0;
              state_nxt = S_EMIT;
            end
          endcase
          if (op_r == pdwg_pkg::OP_FPD) state_nxt = S_FAULT;
        end
      end
      S_RESID: begin
        cmd.resid = 1'b1;
        op_nxt    = pdwg_pkg::OP_FRAC;
        state_nxt = S_DIV_GO;
      end
      S_SWAP: begin
        cmd.gcd_swap = 1'b1;
        state_nxt    = S_GCD_TEST;
      end
      S_EMIT: begin
        idx_nxt = idx_r + 4'd1;
        if ((target_q == pdwg_pkg::TGT_FRAC && idx_r == 4'd8) ||
            (target_q != pdwg_pkg::TGT_FRAC && idx_r == 4'd3)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // After Fpd the zero check decides; the fault state reuses its slot.
    if (state_r == S_FAULT && target_q == pdwg_pkg::TGT_FRAC && op_r == pdwg_pkg::OP_N) begin
      cmd       = '0;
      cmd.op    = op_r;
      state_nxt = stat.fpd_zero ? S_IDLE : S_DIV_GO;
    end
    if (state_r == S_FAULT && target_q != pdwg_pkg::TGT_FRAC) begin
      state_nxt = S_IDLE;
    end
  end

  // State and registered controls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= pdwg_pkg::OP_FPD;
      idx_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // A FRAC division ending moves to emission.
  assign busy       = !idle;
  assign emit       = (state_r == S_EMIT) ||
                      (state_r == S_FAULT &&
                       (target_q != pdwg_pkg::TGT_FRAC || stat.fpd_zero));
  assign emit_fault = (state_r == S_FAULT);
  assign emit_idx   = idx_r;

endmodule

>>> rtl/pll_divider_word_generator.sv
// PLL divider word generator: accepts a request when start is high, busy is
// low and in_target is not 3, then issues the words one per cycle on out_valid;
// the receiver cannot stall. The fractional-N target runs three divisions on the
// shared bit-serial divider and then issues nine words; the integer-N targets
// run one division per Euclid step, then two divisions and four words.
// Depends on pdwg_pkg, pdwg_ctrl and pdwg_datapath.
module pll_divider_word_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_target,
  input  logic [31:0] in_freq_hz,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output logic [23:0] out_word,
  output logic [4:0]  out_bit_count,
  output logic [1:0]  out_dest,
  output logic        out_fault,
  output logic        out_last
);

  logic [31:0] ref_hz_r;
  logic [4:0]  ref_div_r, pump_r;
  logic        lock_r;
  pdwg_pkg::dp_cmd_t  cmd;
  pdwg_pkg::dp_stat_t stat;
  logic [8:0]  div_word;
  logic [17:0] frac_word;
  logic [31:0] r_div, n_div;
  logic [1:0]  target_q;
  logic        emit, emit_fault;
  logic [3:0]  emit_idx;
  logic [23:0] word_nxt;
  logic        frac_t;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_hz_r  <= 32'd19200000;
      ref_div_r <= 5'd0;
      lock_r    <= 1'b0;
      pump_r    <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdwg_pkg::CFG_REF_HZ:  ref_hz_r  <= cfg_data;
        pdwg_pkg::CFG_REF_DIV: ref_div_r <= cfg_data[4:0];
        pdwg_pkg::CFG_LOCK:    lock_r    <= cfg_data[0];
        default:               pump_r    <= cfg_data[4:0];
      endcase
    end
  end

  pdwg_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_target, .stat, .target_q, .cmd, .busy,
    .emit, .emit_fault, .emit_idx
  );

  pdwg_datapath u_dp (
    .clk, .in_target, .in_freq_hz, .reference_hz(ref_hz_r),
    .reference_divider(ref_div_r), .cmd, .stat, .div_word, .frac_word,
    .r_div, .n_div, .target_q
  );

  assign frac_t = (target_q == pdwg_pkg::TGT_FRAC);

  // Word selection.
  always_comb begin
    word_nxt = '0;
    if (frac_t) begin
      case (emit_idx)
        4'd0: word_nxt = {15'h0000, div_word};
        4'd1: word_nxt = {12'h001, 2'b0, frac_word[17:8]};
        4'd2: word_nxt = {16'h0020, frac_word[7:0]};
        4'd3: word_nxt = 24'h003000;
        4'd4: word_nxt = 24'h004000;
        4'd5: word_nxt = {19'h00280, ref_div_r};
        4'd6: word_nxt = {18'h00180, lock_r, pump_r};
        4'd7: word_nxt = 24'h007040;
        default: word_nxt = 24'h008000;
      endcase
    end else begin
      case (emit_idx)
        4'd0: word_nxt = pdwg_pkg::INT_PRE_WORD;
        4'd1: word_nxt = {r_div[21:0], 2'b00};
        4'd2: word_nxt = {n_div[15:0], 8'h01};
        default: word_nxt = pdwg_pkg::INT_POST_WORD;
      endcase
    end
    if (emit_fault) word_nxt = '0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
    out_word      <= word_nxt;
    out_bit_count <= frac_t ? pdwg_pkg::BITS_FRAC : pdwg_pkg::BITS_INT;
    out_dest      <= target_q;
    out_fault     <= emit_fault;
    out_last      <= emit_fault || (frac_t ? emit_idx == 4'd8 : emit_idx == 4'd3);
  end

  // A fault result is always the last of its request.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_last) else $error("fault not last");
  // Nothing is issued while idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> busy) else $error("emit while idle");
  // A last result returns the block to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after last");

endmodule
